[sv/aapc_pkg.sv]
package aapc_pkg;

  // fixed field widths
  localparam int COEF_W    = 24;
  localparam int AVG_W     = 12;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_COEF  = 5;

  // divisor width of the shared serial divider (holds 1000 and the sample count)
  localparam int DIV_W = 10;

  // horner accumulator width: |acc| stays below 2^32 for averages up to 4095
  localparam int ACC_W = 34;

  // largest average that still gets a calibrated voltage
  localparam int AVG_MAX = 4095;

  localparam logic [DIV_W-1:0] X_SCALE = 10'd1000;

  // register reset values
  localparam logic [CNT_W-1:0]         COUNT_RST = 8'd100;
  localparam logic signed [COEF_W-1:0] COEF0_RST = 24'sd8773;
  localparam logic signed [COEF_W-1:0] COEF1_RST = 24'sd130912;
  localparam logic signed [COEF_W-1:0] COEF2_RST = -24'sd26962;
  localparam logic signed [COEF_W-1:0] COEF3_RST = 24'sd11588;
  localparam logic signed [COEF_W-1:0] COEF4_RST = -24'sd1720;

  // saturation bounds in accumulator and output width
  localparam logic signed [ACC_W-1:0]  ACC_VMAX = 34'sd8388607;
  localparam logic signed [ACC_W-1:0]  ACC_VMIN = -34'sd8388608;
  localparam logic signed [COEF_W-1:0] VOLT_MAX = 24'sd8388607;
  localparam logic signed [COEF_W-1:0] VOLT_MIN = -24'sd8388608;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_COEF_0       = 3'd1,
    REG_COEF_1       = 3'd2,
    REG_COEF_2       = 3'd3,
    REG_COEF_3       = 3'd4,
    REG_COEF_4       = 3'd5
  } aapc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_DIV_X,
    ST_MUL_START,
    ST_MUL,
    ST_FINISH
  } aapc_state_e;

endpackage

[sv/aapc_div.sv]
module aapc_div #(
  parameter int DW = 28,
  parameter int VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic          done_o
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] den_q, den_d;

  logic [VW:0] trial;
  logic [VW:0] diff;
  logic        ge;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[sv/aapc_mul.sv]
module aapc_mul #(
  parameter int AW = 34,
  parameter int XW = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [XW-1:0]        x_i,
  output logic signed [AW+XW:0] product_o,
  output logic                 done_o
);

  localparam int CW = (XW > 1) ? $clog2(XW) : 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [AW-1:0] a_q, a_d;
  logic [XW-1:0]        x_q, x_d;
  logic signed [AW:0]   hi_q, hi_d;
  logic [XW-1:0]        lo_q, lo_d;

  logic signed [AW:0] addend;
  logic signed [AW:0] psum;

  // shift-add on one multiplier bit per cycle, lsb first
  assign addend = x_q[0] ? {a_q[AW-1], a_q} : '0;
  assign psum   = hi_q + addend;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    x_d    = x_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      x_d    = x_i;
      hi_d   = '0;
      lo_d   = '0;
    end else if (busy_q) begin
      hi_d  = {psum[AW], psum[AW:1]};
      lo_d  = {psum[0], lo_q[XW-1:1]};
      x_d   = x_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(XW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    x_q  <= x_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign product_o = {hi_q, lo_q};
  assign done_o    = done_q;

endmodule

[sv/adc_average_poly_calibrate_core.sv]
// Boxcar averager with quartic calibration for a slow converter.
// Input channel (in_valid_i / in_ready_o / sample_i): one sample per transfer.
// Output channel (out_valid_o / out_ready_i): average, voltage, out_of_range.
// Config port: cfg_we_i with cfg_idx_i and cfg_data_i;
// index 0 is the sample count, 1..5 are coef_0..coef_4, others are ignored.
// A sample that does not close a group is added to the sum. The sample that
// closes a group starts the computation and the input is held off until the
// result sits in the output register: the shared bit-serial divider forms the
// average, then x, and the bit-serial multiplier runs the four horner steps;
// an out-of-range average skips x and the horner steps.
// The output register lets the next group be summed while a result waits;
// if the receiver stalls, a finished result waits in the last state until the
// output register frees up.
// Reset clears the sum and sample counter, drops out_valid_o and restores the
// register defaults (count 100 and the default coefficient set).
module adc_average_poly_calibrate_core #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [aapc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [aapc_pkg::COEF_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [SAMPLE_BITS-1:0]             sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [aapc_pkg::AVG_W-1:0]         average_o,
  output logic signed [aapc_pkg::COEF_W-1:0] voltage_o,
  output logic                               out_of_range_o
);

  import aapc_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int DW    = SAMPLE_BITS + FRAC_BITS;
  localparam int XW    = FRAC_BITS + 3;
  localparam int PW    = ACC_W + 1 + XW;
  localparam int SHW   = PW - FRAC_BITS;

  aapc_state_e state_q, state_d;

  logic [CNT_W-1:0]        count_q, count_d;
  coef_t                   coef_q [NUM_COEF];
  coef_t                   coef_d [NUM_COEF];
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [CNT_W-1:0]        seen_q, seen_d;
  logic [SAMPLE_BITS-1:0]  avg_q, avg_d;
  logic                    oor_q, oor_d;
  logic [XW-1:0]           x_q, x_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [1:0]              step_q, step_d;
  logic                    out_valid_q, out_valid_d;
  logic [AVG_W-1:0]        average_q, average_d;
  coef_t                   voltage_q, voltage_d;
  logic                    out_oor_q, out_oor_d;

  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [DIV_W-1:0]       div_divisor;
  logic [DW-1:0]          div_quo;
  logic                   div_done;
  logic                   mul_start;
  logic signed [PW-1:0]   mul_product;
  logic                   mul_done;

  logic [CNT_W-1:0]        n_eff;
  logic [SUM_W-1:0]        sum_plus;
  logic                    group_done;
  logic [SAMPLE_BITS-1:0]  avg_w;
  logic                    avg_oor;
  logic signed [SHW-1:0]   pshift;
  logic signed [SHW-1:0]   coef_ext;
  logic signed [SHW-1:0]   horner_sum;
  coef_t                   coef_sel;
  coef_t                   volt_sat;
  logic                    out_free;

  // configuration writes
  always_comb begin
    count_d = count_q;
    coef_d  = coef_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SAMPLE_COUNT: count_d = cfg_data_i[CNT_W-1:0];
        REG_COEF_0:       coef_d[0] = cfg_data_i;
        REG_COEF_1:       coef_d[1] = cfg_data_i;
        REG_COEF_2:       coef_d[2] = cfg_data_i;
        REG_COEF_3:       coef_d[3] = cfg_data_i;
        REG_COEF_4:       coef_d[4] = cfg_data_i;
        default:          count_d = count_q;
      endcase
    end
  end

  // accumulate and group detection, a count of zero acts as one
  assign n_eff      = (count_q == '0) ? CNT_W'(1) : count_q;
  assign sum_plus   = sum_q + SUM_W'(sample_i);
  assign group_done = ({1'b0, seen_q} + 1'b1) >= {1'b0, n_eff};

  // average range check on the full quotient
  assign avg_w   = div_quo[SAMPLE_BITS-1:0];
  assign avg_oor = (div_quo == '0) || (div_quo > DW'(AVG_MAX));

  // horner step: floor shift of the product plus the next coefficient
  assign coef_sel   = coef_q[{1'b0, step_q}];
  assign pshift     = mul_product[PW-1:FRAC_BITS];
  assign coef_ext   = {{(SHW-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
  assign horner_sum = pshift + coef_ext;

  // saturation to the output range
  always_comb begin
    if (acc_q > ACC_VMAX) begin
      volt_sat = VOLT_MAX;
    end else if (acc_q < ACC_VMIN) begin
      volt_sat = VOLT_MIN;
    end else begin
      volt_sat = acc_q[COEF_W-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    seen_d       = seen_q;
    avg_d        = avg_q;
    oor_d        = oor_q;
    x_d          = x_q;
    acc_d        = acc_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    average_d    = average_q;
    voltage_d    = voltage_q;
    out_oor_d    = out_oor_q;
    div_start    = 1'b0;
    div_dividend = DW'(sum_plus);
    div_divisor  = DIV_W'(n_eff);
    mul_start    = 1'b0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (group_done) begin
            sum_d     = '0;
            seen_d    = '0;
            div_start = 1'b1;
            state_d   = ST_DIV_AVG;
          end else begin
            sum_d  = sum_plus;
            seen_d = seen_q + 1'b1;
          end
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          avg_d = avg_w;
          if (avg_oor) begin
            oor_d   = 1'b1;
            acc_d   = '0;
            state_d = ST_FINISH;
          end else begin
            oor_d        = 1'b0;
            div_dividend = {avg_w, {FRAC_BITS{1'b0}}};
            div_divisor  = X_SCALE;
            div_start    = 1'b1;
            state_d      = ST_DIV_X;
          end
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          x_d     = div_quo[XW-1:0];
          acc_d   = {{(ACC_W-COEF_W){coef_q[NUM_COEF-1][COEF_W-1]}}, coef_q[NUM_COEF-1]};
          step_d  = 2'(NUM_COEF - 2);
          state_d = ST_MUL_START;
        end
      end
      ST_MUL_START: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          acc_d = horner_sum[ACC_W-1:0];
          if (step_q == 2'd0) begin
            state_d = ST_FINISH;
          end else begin
            step_d  = step_q - 1'b1;
            state_d = ST_MUL_START;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          average_d   = AVG_W'(avg_q);
          voltage_d   = volt_sat;
          out_oor_d   = oor_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  aapc_div #(
    .DW(DW),
    .VW(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  aapc_mul #(
    .AW(ACC_W),
    .XW(XW)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (acc_q),
    .x_i       (x_q),
    .product_o (mul_product),
    .done_o    (mul_done)
  );

  // control state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= COUNT_RST;
      coef_q[0]   <= COEF0_RST;
      coef_q[1]   <= COEF1_RST;
      coef_q[2]   <= COEF2_RST;
      coef_q[3]   <= COEF3_RST;
      coef_q[4]   <= COEF4_RST;
      sum_q       <= '0;
      seen_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      coef_q      <= coef_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    avg_q     <= avg_d;
    oor_q     <= oor_d;
    x_q       <= x_d;
    acc_q     <= acc_d;
    average_q <= average_d;
    voltage_q <= voltage_d;
    out_oor_q <= out_oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign average_o      = average_q;
  assign voltage_o      = voltage_q;
  assign out_of_range_o = out_oor_q;

endmodule

[sv/aapc_checker.sv]
module aapc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] average_o,
  input logic [23:0] voltage_o,
  input logic        out_of_range_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(voltage_o) && $stable(average_o))
    else $error("stalled result dropped or changed");

  // a new result only follows a compute phase with the input held off
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a compute phase");

  // out of range forces the voltage to zero
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> voltage_o == 24'd0)
    else $error("out of range result with nonzero voltage");

  // an in-range result never carries a zero average
  a_avg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |-> average_o != 12'd0)
    else $error("zero average not flagged out of range");

endmodule

bind adc_average_poly_calibrate_core aapc_checker u_aapc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .average_o      (average_o),
  .voltage_o      (voltage_o),
  .out_of_range_o (out_of_range_o)
);
